[rtl/car_pkg.sv]
// shared constants, register map and types for the cusum attitude recovery switch
package car_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int SUM_WIDTH_DEF   = 24;
    localparam int NUM_AXES        = 3;

    localparam int BIAS_W   = 16;
    localparam int LIMIT_W  = 24;
    localparam int MARGIN_W = 16;

    localparam int APB_DW = 32;
    localparam int APB_AW = 5;

    localparam logic [BIAS_W-1:0]   BIAS_RST   = '0;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = '1;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(26);  // 0.1 in q8.8

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_BIAS_ROLL   = 3'd0,
        REG_BIAS_PITCH  = 3'd1,
        REG_BIAS_YAW    = 3'd2,
        REG_LIMIT_ROLL  = 3'd3,
        REG_LIMIT_PITCH = 3'd4,
        REG_LIMIT_YAW   = 3'd5,
        REG_MARGIN      = 3'd6
    } t_reg_idx;

    // per-axis status back to the flag logic
    typedef struct packed {
        logic trig;    // updated sum above limit
        logic rel_ok;  // |residual - bias| under release margin
    } t_axis_stat;

endpackage

[rtl/cusum_attitude_recovery_switch_top.sv]
// top level: stream ports, apb register file, input and result registers, recovery flag
//
// channel  | direction | payload                                     | handshake
// s_axis   | in        | model roll/pitch/yaw, pid roll/pitch/yaw    | tvalid/tready
// m_axis   | out       | out roll/pitch/yaw in tdata, in_recovery    | tvalid/tready
// apb      | in        | bias x3, limit x3, release margin           | psel/penable
//
// one item per cycle while the output is not stalled; an accepted input goes to the
// input register, then the three axis updates and the flag are computed into the
// result register. sums and flag move only when an item passes to the result
// register, so a stalled output holds all state. reset clears sums, flag, registers
// to their reset values and both valid bits.
module cusum_attitude_recovery_switch_top
    import car_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
    localparam int IN_W  = ((NUM_AXES * 2 * ANGLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((NUM_AXES * ANGLE_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // model_roll, model_pitch, model_yaw, pid_roll, pid_pitch, pid_yaw, zero pad
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // out_roll, out_pitch, out_yaw, zero pad
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    // in_recovery
    output logic              o_m_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = ANGLE_WIDTH;

    logic [BIAS_W-1:0]   r_bias  [NUM_AXES];
    logic [LIMIT_W-1:0]  r_limit [NUM_AXES];
    logic [MARGIN_W-1:0] r_margin;

    logic                r_in_valid;
    logic [IN_W-1:0]     r_in_data;
    logic [SUM_WIDTH-1:0] r_sum [NUM_AXES];
    logic                r_flag;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic                r_out_rec;

    logic [SUM_WIDTH-1:0] n_sum [NUM_AXES];
    t_axis_stat           stat  [NUM_AXES];
    logic                 n_flag;
    logic [OUT_W-1:0]     n_out_data;
    logic                 advance;
    logic                 any_trig;
    logic                 all_rel;
    logic                 cfg_wr;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_bias[k]  <= BIAS_RST;
                r_limit[k] <= LIMIT_RST;
            end
            r_margin <= MARGIN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BIAS_ROLL:   r_bias[0]  <= pwdata[BIAS_W-1:0];
                REG_BIAS_PITCH:  r_bias[1]  <= pwdata[BIAS_W-1:0];
                REG_BIAS_YAW:    r_bias[2]  <= pwdata[BIAS_W-1:0];
                REG_LIMIT_ROLL:  r_limit[0] <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_PITCH: r_limit[1] <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_YAW:   r_limit[2] <= pwdata[LIMIT_W-1:0];
                REG_MARGIN:      r_margin   <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIAS_ROLL:   prdata = APB_DW'(r_bias[0]);
            REG_BIAS_PITCH:  prdata = APB_DW'(r_bias[1]);
            REG_BIAS_YAW:    prdata = APB_DW'(r_bias[2]);
            REG_LIMIT_ROLL:  prdata = APB_DW'(r_limit[0]);
            REG_LIMIT_PITCH: prdata = APB_DW'(r_limit[1]);
            REG_LIMIT_YAW:   prdata = APB_DW'(r_limit[2]);
            REG_MARGIN:      prdata = APB_DW'(r_margin);
            default:         prdata = '0;
        endcase
    end

    // the input register empties whenever the result register is free or draining
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        car_axis #(
            .ANGLE_WIDTH (ANGLE_WIDTH),
            .SUM_WIDTH   (SUM_WIDTH)
        ) u_axis (
            .i_model  (r_in_data[g*AW +: AW]),
            .i_pid    (r_in_data[(g+NUM_AXES)*AW +: AW]),
            .i_sum    (r_sum[g]),
            .i_bias   (r_bias[g]),
            .i_limit  (r_limit[g]),
            .i_margin (r_margin),
            .o_sum    (n_sum[g]),
            .o_stat   (stat[g])
        );
    end

    always_comb begin
        any_trig = 1'b0;
        all_rel  = 1'b1;
        for (int k = 0; k < NUM_AXES; k++) begin
            any_trig = any_trig | stat[k].trig;
            all_rel  = all_rel & stat[k].rel_ok;
        end
        // trigger first, then release may drop the flag in the same step
        n_flag     = (r_flag || any_trig) && !all_rel;
        n_out_data = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            n_out_data[k*AW +: AW] = n_flag ? r_in_data[k*AW +: AW]
                                            : r_in_data[(k+NUM_AXES)*AW +: AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flag      <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flag      <= n_flag;
                for (int k = 0; k < NUM_AXES; k++) begin
                    r_sum[k] <= n_sum[k];
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out_data <= n_out_data;
            r_out_rec  <= n_flag;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_rec;

    a_flag_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_m_axis_tuser == r_flag) && o_m_axis_tvalid)
        else $error("recovery flag and result tuser disagree");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_flag) && $stable(r_sum[0]) && $stable(r_sum[1])
                     && $stable(r_sum[2]))
        else $error("cusum state moved without a transaction");

    a_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending input item dropped");

    a_flag_rise_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_flag) |-> $past(advance))
        else $error("recovery flag set without an item");

endmodule

[rtl/car_axis.sv]
// one axis: residual, saturating one-sided cusum update, trigger and release tests
module car_axis
    import car_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int SUM_WIDTH   = SUM_WIDTH_DEF
) (
    input  logic [ANGLE_WIDTH-1:0] i_model,
    input  logic [ANGLE_WIDTH-1:0] i_pid,
    input  logic [SUM_WIDTH-1:0]   i_sum,
    input  logic [BIAS_W-1:0]      i_bias,
    input  logic [LIMIT_W-1:0]     i_limit,
    input  logic [MARGIN_W-1:0]    i_margin,
    output logic [SUM_WIDTH-1:0]   o_sum,
    output t_axis_stat             o_stat
);

    localparam int DW  = ANGLE_WIDTH + 1;
    localparam int M1  = (SUM_WIDTH > DW) ? SUM_WIDTH : DW;
    localparam int CW  = ((M1 > BIAS_W) ? M1 : BIAS_W) + 2;
    localparam int RW  = (SUM_WIDTH > LIMIT_W) ? SUM_WIDTH : LIMIT_W;
    localparam int RDW = ((DW > BIAS_W) ? DW : BIAS_W) + 1;

    logic [DW-1:0]  diff;
    logic [DW-1:0]  resid;
    logic [CW-1:0]  acc;
    logic [RDW-1:0] rdiff;
    logic [RDW-1:0] rmag;

    always_comb begin
        diff  = {i_model[ANGLE_WIDTH-1], i_model} - {i_pid[ANGLE_WIDTH-1], i_pid};
        resid = diff[DW-1] ? (~diff + DW'(1)) : diff;

        acc = CW'(i_sum) + CW'(resid) - CW'(i_bias);
        if (acc[CW-1]) begin
            o_sum = '0;
        end else if (acc[CW-2:SUM_WIDTH] != '0) begin
            o_sum = '1;
        end else begin
            o_sum = acc[SUM_WIDTH-1:0];
        end

        rdiff = RDW'(resid) - RDW'(i_bias);
        rmag  = rdiff[RDW-1] ? (~rdiff + RDW'(1)) : rdiff;

        o_stat.trig   = RW'(o_sum) > RW'(i_limit);
        o_stat.rel_ok = rmag < RDW'(i_margin);
    end

endmodule

[tb/cusum_attitude_recovery_switch_top_test.sv]
// testbench for the cusum attitude recovery switch: stream traffic checked against a predictor
`timescale 1ns / 100ps

module cusum_attitude_recovery_switch_top_test;
    import car_pkg::*;

    localparam int IN_W        = 96;
    localparam int OUT_W       = 48;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 8;
    localparam int STORM_ITEMS = 320;
    localparam int PHASE_ITEMS = 155;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               recovery;
    } t_attitude_sel;

    class t_attitude_scoreboard;
        logic [15:0]   bias [3];
        logic [23:0]   limit [3];
        logic [15:0]   margin;
        logic [23:0]   cusum [3];
        logic          recovering;
        t_attitude_sel selection_q [$];
        int            fails;

        function new();
            for (int i = 0; i < 3; i++) begin
                bias[i]  = BIAS_RST;
                limit[i] = LIMIT_RST;
                cusum[i] = '0;
            end
            margin     = MARGIN_RST;
            recovering = 1'b0;
            fails      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_BIAS_ROLL, REG_BIAS_PITCH, REG_BIAS_YAW: begin
                    bias[idx] = value[15:0];
                end
                REG_LIMIT_ROLL, REG_LIMIT_PITCH, REG_LIMIT_YAW: begin
                    limit[idx - REG_LIMIT_ROLL] = value[23:0];
                end
                REG_MARGIN: begin
                    margin = value[15:0];
                end
                default: begin
                end
            endcase
        endfunction

        // one accepted input transaction: advance the sums and the flag, queue the selection
        function void note_input(logic [IN_W-1:0] d);
            longint        mdl, pid, s;
            longint        resid [3];
            bit            release_ok;
            t_attitude_sel e;
            for (int i = 0; i < 3; i++) begin
                mdl      = longint'($signed(d[16*i +: 16]));
                pid      = longint'($signed(d[16*(i+3) +: 16]));
                resid[i] = (mdl > pid) ? mdl - pid : pid - mdl;
                s = longint'(cusum[i]) + resid[i] - longint'(bias[i]);
                if (s < 0) s = 0;
                if (s > 64'hFF_FFFF) s = 64'hFF_FFFF;
                cusum[i] = s[23:0];
            end
            for (int i = 0; i < 3; i++) begin
                if (longint'(cusum[i]) > longint'(limit[i])) recovering = 1'b1;
            end
            // release is tested after the trigger, in the same step
            if (recovering) begin
                release_ok = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    s = resid[i] - longint'(bias[i]);
                    if (s < 0) s = -s;
                    if (s >= longint'(margin)) release_ok = 1'b0;
                end
                if (release_ok) recovering = 1'b0;
            end
            e.roll     = recovering ? d[15:0]  : d[63:48];
            e.pitch    = recovering ? d[31:16] : d[79:64];
            e.yaw      = recovering ? d[47:32] : d[95:80];
            e.recovery = recovering;
            selection_q.push_back(e);
        endfunction

        function void flag_mismatch(string field, longint want, longint got);
            fails++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(logic [OUT_W-1:0] d, logic rec);
            t_attitude_sel e;
            if (selection_q.size() == 0) begin
                fails++;
                $error("result with nothing expected: tdata %h tuser %b", d, rec);
                return;
            end
            e = selection_q.pop_front();
            if (d[15:0] !== e.roll)     flag_mismatch("out_roll", e.roll, $signed(d[15:0]));
            if (d[31:16] !== e.pitch)   flag_mismatch("out_pitch", e.pitch, $signed(d[31:16]));
            if (d[47:32] !== e.yaw)     flag_mismatch("out_yaw", e.yaw, $signed(d[47:32]));
            if (rec !== e.recovery)     flag_mismatch("in_recovery", e.recovery, rec);
        endfunction

        function int pending();
            return selection_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;
    logic              i_m_axis_tready = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic              o_m_axis_tuser;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    t_attitude_scoreboard sb = new();

    logic [15:0] cfg_bias [3];
    logic [23:0] cfg_limit [3];
    logic [15:0] cfg_margin;
    int          idle_max = 12;
    int          rx_hold = 0;
    bit          storm = 1'b0;
    int          cycle_count = 0;

    cusum_attitude_recovery_switch_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[cusum_attitude_recovery_switch_top] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // result side: random stall per transaction, plus one long hold-off on request
    initial begin
        int w;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            w = $urandom_range(0, idle_max);
            if (w > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // upper bits carry junk that the block must drop
    task automatic program_regs();
        logic [31:0] junk;
        for (int i = 0; i < 3; i++) begin
            junk = $urandom;
            apb_write(3'(REG_BIAS_ROLL + i), {junk[31:16], cfg_bias[i]});
            junk = $urandom;
            apb_write(3'(REG_LIMIT_ROLL + i), {junk[31:24], cfg_limit[i]});
        end
        junk = $urandom;
        apb_write(REG_MARGIN, {junk[31:16], cfg_margin});
        apb_write(REG_UNMAPPED, $urandom);
    endtask

    task automatic send_item(logic [IN_W-1:0] item);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= item;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(item);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack6(int mr, int mp, int my, int pr, int pp, int py);
        return {16'(py), 16'(pp), 16'(pr), 16'(my), 16'(mp), 16'(mr)};
    endfunction

    function automatic logic [15:0] corner_angle();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // residuals mostly placed around or above the bias so the flag can both set and clear
    function automatic logic [IN_W-1:0] make_item();
        logic [IN_W-1:0] item;
        logic [15:0]     a, b, t;
        int              pick, r, m, lo;
        pick = storm ? 65 : $urandom_range(0, 99);
        if (pick >= 85) begin
            for (int f = 0; f < 6; f++) item[16*f +: 16] = corner_angle();
        end else if (pick >= 75) begin
            item = {$urandom, $urandom, $urandom};
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (pick < 40) begin
                    m = (cfg_margin > 200) ? 200 : int'(cfg_margin);
                    r = int'(cfg_bias[i]) + int'($urandom_range(0, 2*m + 4)) - (m + 2);
                end else if (pick < 65) begin
                    r = int'(cfg_bias[i]) + int'($urandom_range(0, 3000));
                end else begin
                    r = int'($urandom_range(60000, 65535));
                end
                if (r < 0) r = 0;
                if (r > 65535) r = 65535;
                lo = -32768 + int'($urandom_range(0, 65535 - r));
                a  = 16'(lo);
                b  = 16'(lo + r);
                if ($urandom_range(0, 1)) begin
                    t = a;
                    a = b;
                    b = t;
                end
                item[16*i +: 16]     = a;
                item[16*(i+3) +: 16] = b;
            end
        end
        return item;
    endfunction

    function automatic logic [15:0] pick_bias();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hffff;
            2, 3: return 16'($urandom_range(0, 400));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hff_ffff;
            2, 3: return 24'($urandom_range(0, 20000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_margin();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hffff;
            2: return MARGIN_RST;
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    initial begin
        int count;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration, field extremes
        send_item(pack6(32767, 32767, 32767, -32768, -32768, -32768));
        send_item(pack6(-32768, -32768, -32768, 32767, 32767, 32767));
        send_item(pack6(0, 0, 0, 0, 0, 0));
        send_item(pack6(-1, 1, -32768, 1, -1, -32768));
        send_item(pack6(12345, -200, 7, -9876, 300, -7));
        drain();

        for (int i = 0; i < 3; i++) begin
            cfg_bias[i]  = 16'd100;
            cfg_limit[i] = 24'd1000;
        end
        cfg_margin = MARGIN_RST;
        program_regs();
        send_item(pack6(100, 100, 100, 0, 0, 0));
        send_item(pack6(0, 0, 0, 50, 50, 50));        // sums clamp at zero
        send_item(pack6(800, 100, 100, 0, 0, 0));
        send_item(pack6(0, 100, 100, 500, 0, 0));     // roll crosses its limit
        send_item(pack6(300, -100, -100, 0, 0, 0));
        send_item(pack6(110, 110, 110, 0, 0, 0));     // trigger and release together
        send_item(pack6(-90, -90, -90, 0, 0, 0));
        send_item(pack6(0, 5000, 0, 0, 0, 0));
        send_item(pack6(100, 100, 100, 0, 0, 0));
        send_item(pack6(0, 0, 0, 0, 0, 0));
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int i = 0; i < 3; i++) begin
                cfg_bias[i]  = pick_bias();
                cfg_limit[i] = pick_limit();
            end
            cfg_margin = pick_margin();
            storm = 1'b0;
            count = PHASE_ITEMS;
            case (ph)
                0: begin
                    // huge residuals with full limits: sums saturate, never trigger
                    for (int i = 0; i < 3; i++) begin
                        cfg_bias[i]  = 16'd0;
                        cfg_limit[i] = 24'hff_ffff;
                    end
                    cfg_margin = MARGIN_RST;
                    storm = 1'b1;
                    count = STORM_ITEMS;
                end
                1: begin
                    cfg_bias[0] = 16'hffff;
                    cfg_bias[1] = 16'd0;
                    cfg_bias[2] = 16'd300;
                    for (int i = 0; i < 3; i++) cfg_limit[i] = 24'd0;
                    cfg_margin = 16'hffff;
                end
                2: begin
                    cfg_margin = 16'd0;
                end
                default: begin
                end
            endcase
            program_regs();
            idle_max = (ph == 2 || ph == 6) ? 0 : 12;
            if (ph == 3) rx_hold = 250;
            for (int n = 0; n < count; n++) begin
                if (ph == 5 && n == count / 2) drain();
                send_item(make_item());
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("[cusum_attitude_recovery_switch_top] OK");
        end else begin
            $display("[cusum_attitude_recovery_switch_top] ERROR");
        end
        $finish;
    end

endmodule
